// ===== design/deq_pkg.sv =====
package deq_pkg;

   localparam int unsigned KIND_WIDTH   = 3;
   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned FILL_WIDTH   = 5;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH_R = 3'd0,
      KIND_POP_L  = 3'd1,
      KIND_POP_R  = 3'd2,
      KIND_PEEK_L = 3'd3,
      KIND_PEEK_R = 3'd4
   } kind_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic exec;      // update pointers, write or read the store
      logic load;      // move the result into the response register
   } cmd_type;

endpackage

// ===== design/deq_ctrl.sv =====
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output deq_pkg::cmd_type cmd
);

   deq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         deq_pkg::S_IDLE: begin
            if (req_valid) state_in = deq_pkg::S_EXEC;
         end
         deq_pkg::S_EXEC: begin
            state_in = deq_pkg::S_LOAD;
         end
         deq_pkg::S_LOAD: begin
            if (slot_free) state_in = deq_pkg::S_IDLE;
         end
         default: begin
            state_in = deq_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      cmd.load    = 1'b0;
      unique case (state_ff)
         deq_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         deq_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
         end
         deq_pkg::S_LOAD: begin
            cmd.load = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a response still waiting");

   a_exec_follows_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec)
      else $error("accepted request not executed next cycle");

endmodule

// ===== design/deq_dpath.sv =====
module deq_dpath #(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned ITEM_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  deq_pkg::cmd_type                   cmd,
   input  logic [deq_pkg::KIND_WIDTH-1:0]     req_kind,
   input  logic [deq_pkg::VALUE_WIDTH-1:0]    req_push_value,
   output logic [deq_pkg::VALUE_WIDTH-1:0]    rsp_item_value,
   output logic [deq_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic                               rsp_is_empty,
   output logic [deq_pkg::FILL_WIDTH-1:0]     rsp_fill_count
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // circular store, one write or one read per operation
   logic [ITEM_WIDTH-1:0] mem [DEPTH];

   logic [ITEM_WIDTH-1:0]          value_ff;
   deq_pkg::kind_type              kind_ff;
   logic [AW-1:0]                  left_ff, left_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [ITEM_WIDTH-1:0]          rdata_ff;
   deq_pkg::status_type            status_ff, status_in;
   logic                           hit_ff, hit_in;
   logic [deq_pkg::VALUE_WIDTH-1:0]  item_out_ff;
   deq_pkg::status_type            status_out_ff;
   logic                           empty_out_ff;
   logic [deq_pkg::FILL_WIDTH-1:0] fill_out_ff;

   logic          is_empty, is_full;
   logic          mem_we, rd_en;
   logic [AW-1:0] wr_addr, rd_addr, tail_pos, right_pos;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos,
                                              input logic [AW-1:0] off);
      logic [AW:0] s;
      s = {1'b0, pos} + {1'b0, off};
      if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
      return s[AW-1:0];
   endfunction

   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign tail_pos  = wrap_add(left_ff, count_ff[AW-1:0]);
   assign right_pos = wrap_add(left_ff, AW'(count_ff - CW'(1)));

   // operation decode
   always_comb begin
      left_in   = left_ff;
      count_in  = count_ff;
      status_in = deq_pkg::STAT_OK;
      hit_in    = 1'b0;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_pos;
      rd_addr   = left_ff;
      unique case (kind_ff)
         deq_pkg::KIND_PUSH_R: begin
            if (is_full) begin
               status_in = deq_pkg::STAT_FULL;
            end else begin
               mem_we   = cmd.exec;
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::KIND_POP_L, deq_pkg::KIND_PEEK_L: begin
            if (is_empty) begin
               status_in = deq_pkg::STAT_EMPTY;
            end else begin
               hit_in = 1'b1;
               rd_en  = cmd.exec;
               if (kind_ff == deq_pkg::KIND_POP_L) begin
                  left_in  = wrap_add(left_ff, AW'(1));
                  count_in = count_ff - CW'(1);
               end
            end
         end
         deq_pkg::KIND_POP_R, deq_pkg::KIND_PEEK_R: begin
            rd_addr = right_pos;
            if (is_empty) begin
               status_in = deq_pkg::STAT_EMPTY;
            end else begin
               hit_in = 1'b1;
               rd_en  = cmd.exec;
               if (kind_ff == deq_pkg::KIND_POP_R) count_in = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= value_ff;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         left_ff  <= left_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= deq_pkg::kind_type'(req_kind);
         value_ff <= ITEM_WIDTH'(req_push_value);
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         hit_ff    <= hit_in;
      end
      if (cmd.load) begin
         item_out_ff   <= hit_ff ? deq_pkg::VALUE_WIDTH'(rdata_ff) : '0;
         status_out_ff <= status_ff;
         empty_out_ff  <= is_empty;
         fill_out_ff   <= deq_pkg::FILL_WIDTH'(count_ff);
      end
   end

   assign rsp_item_value = item_out_ff;
   assign rsp_status     = status_out_ff;
   assign rsp_is_empty   = empty_out_ff;
   assign rsp_fill_count = fill_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("item count above depth");

   a_full_only_at_depth: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && status_in == deq_pkg::STAT_FULL) |-> is_full)
      else $error("push refused while space remains");

   a_empty_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && status_in == deq_pkg::STAT_EMPTY)
      |=> (count_ff == '0) && $stable(left_ff))
      else $error("failed pop or peek changed the deque");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && rd_en))
      else $error("store written and read by one operation");

endmodule

// ===== design/double_ended_queue.sv =====
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_kind, req_push_value
// rsp       rsp_valid/rsp_ready    rsp_item_value, rsp_status, rsp_is_empty,
//                                  rsp_fill_count
//
// Sequence: each request is accepted, executed and its result loaded, in steps
//   set by the registered read port of the item store and the three-step sequencer.
// Reset: synchronous, active high; deque becomes empty, left pointer at 0.
//   Store contents are not cleared.
// Stalls: the response sits in its own register, so the next request is
//   taken while a result waits; the sequencer holds in its load step only
//   when that register is still full.
module double_ended_queue #(
   parameter int unsigned DEPTH      = 16,   // 2 .. 31 entries
   parameter int unsigned ITEM_WIDTH = 32    // 1 .. 32 bits stored per entry
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [deq_pkg::KIND_WIDTH-1:0]    req_kind,
   input  logic [deq_pkg::VALUE_WIDTH-1:0]   req_push_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [deq_pkg::VALUE_WIDTH-1:0]   rsp_item_value,
   output logic [deq_pkg::STATUS_WIDTH-1:0]  rsp_status,
   output logic                              rsp_is_empty,
   output logic [deq_pkg::FILL_WIDTH-1:0]    rsp_fill_count
);

   // sequencer commands into the datapath
   deq_pkg::cmd_type cmd;

   // controller: accept, execute, load; owns the response valid flag
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: circular store, left pointer, item count, response register
   deq_dpath #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_fill_count (rsp_fill_count)
   );

endmodule

// ===== test/deque_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the deque, keeps a shadow copy of its contents
// and compares every response with the oldest predicted one.
module deque_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [deq_pkg::KIND_WIDTH-1:0]   req_kind,
   input  logic [deq_pkg::VALUE_WIDTH-1:0]  req_push_value,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [deq_pkg::VALUE_WIDTH-1:0]  rsp_item_value,
   input  logic [deq_pkg::STATUS_WIDTH-1:0] rsp_status,
   input  logic                             rsp_is_empty,
   input  logic [deq_pkg::FILL_WIDTH-1:0]   rsp_fill_count,
   output int                               mismatch_count,
   output int                               pending_count
);

   localparam int unsigned SLOTS = 16;

   typedef struct packed {
      logic [deq_pkg::VALUE_WIDTH-1:0] item_value;
      deq_pkg::status_type             status;
      logic                            is_empty;
      logic [deq_pkg::FILL_WIDTH-1:0]  fill_count;
   } deque_result_type;

   logic [deq_pkg::VALUE_WIDTH-1:0] shadow_store [SLOTS];
   logic [3:0]                      head_ptr;
   logic [deq_pkg::FILL_WIDTH-1:0]  held;
   deque_result_type                predicted_rsps [$];
   int                              mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string field,
                                  input logic [deq_pkg::VALUE_WIDTH-1:0] got,
                                  input logic [deq_pkg::VALUE_WIDTH-1:0] want);
      $display("%0t: response mismatch on %s: got %0h, want %0h", $time, field, got, want);
      mismatches++;
   endtask

   // Applies one operation to the shadow deque and returns its response.
   function automatic deque_result_type apply_deque_op(
      input logic [deq_pkg::KIND_WIDTH-1:0]  kind,
      input logic [deq_pkg::VALUE_WIDTH-1:0] value);
      deque_result_type res;
      logic [3:0]       slot;
      res = '{item_value: '0, status: deq_pkg::STAT_OK, is_empty: 1'b0, fill_count: '0};
      case (kind)
         deq_pkg::KIND_PUSH_R: begin
            if (held == SLOTS) begin
               res.status = deq_pkg::STAT_FULL;
            end else begin
               slot = head_ptr + held[3:0];
               shadow_store[slot] = value;
               held++;
            end
         end
         deq_pkg::KIND_POP_L, deq_pkg::KIND_POP_R,
         deq_pkg::KIND_PEEK_L, deq_pkg::KIND_PEEK_R: begin
            if (held == 0) begin
               res.status = deq_pkg::STAT_EMPTY;
            end else begin
               if (kind == deq_pkg::KIND_POP_L || kind == deq_pkg::KIND_PEEK_L)
                  slot = head_ptr;
               else
                  slot = head_ptr + held[3:0] - 4'd1;
               res.item_value = shadow_store[slot];
               if (kind == deq_pkg::KIND_POP_L) begin
                  head_ptr++;
                  held--;
               end else if (kind == deq_pkg::KIND_POP_R) begin
                  held--;
               end
            end
         end
         default: ;  // unused kinds leave the deque alone
      endcase
      res.is_empty   = (held == 0);
      res.fill_count = held;
      return res;
   endfunction

   always @(posedge clock) begin
      deque_result_type want;
      if (reset) begin
         head_ptr = '0;
         held     = '0;
         predicted_rsps.delete();
      end else begin
         // responses first: one leaving now always belongs to an older request
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch("unexpected response", rsp_item_value, '0);
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_item_value !== want.item_value)
                  report_mismatch("item_value", rsp_item_value, want.item_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", deq_pkg::VALUE_WIDTH'(rsp_status),
                                  deq_pkg::VALUE_WIDTH'(want.status));
               if (rsp_is_empty !== want.is_empty)
                  report_mismatch("is_empty", deq_pkg::VALUE_WIDTH'(rsp_is_empty),
                                  deq_pkg::VALUE_WIDTH'(want.is_empty));
               if (rsp_fill_count !== want.fill_count)
                  report_mismatch("fill_count", deq_pkg::VALUE_WIDTH'(rsp_fill_count),
                                  deq_pkg::VALUE_WIDTH'(want.fill_count));
            end
         end
         if (req_valid && req_ready)
            predicted_rsps.insert(predicted_rsps.size(),
                                  apply_deque_op(req_kind, req_push_value));
      end
      pending_count <= predicted_rsps.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // run shape
   localparam int RANDOM_ITEMS  = 1925;
   localparam int CHUNK_ITEMS   = 40;     // requests per bias phase
   localparam int IDLE_PCT      = 13;     // chance of a gap or a stall per cycle
   localparam int NOISE_PCT     = 3;      // share of unused kinds in random traffic
   localparam int HOLD_AT       = 300;    // receiver blocks after this many requests
   localparam int HOLD_CYCLES   = 120;
   localparam int CALM_FIRST    = 500;    // no gaps, no stalls within this window
   localparam int CALM_LAST     = 800;
   localparam int DRAIN_AT      = 1000;   // sender waits for every response here
   localparam int TAIL_CYCLES   = 12;
   localparam int TIMEOUT_NS    = 2_000_000;

   // kinds the block has no operation for
   localparam int KIND_SPARE_LO = 5;
   localparam int KIND_SPARE_HI = 7;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [deq_pkg::KIND_WIDTH-1:0]   req_kind;
   logic [deq_pkg::VALUE_WIDTH-1:0]  req_push_value;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [deq_pkg::VALUE_WIDTH-1:0]  rsp_item_value;
   logic [deq_pkg::STATUS_WIDTH-1:0] rsp_status;
   logic                             rsp_is_empty;
   logic [deq_pkg::FILL_WIDTH-1:0]   rsp_fill_count;

   int   mismatch_count;
   int   pending_count;
   logic calm = 1'b0;       // set by the request side, read by the response side
   logic hold_due = 1'b0;   // request side asks, response side clears

   double_ended_queue u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_fill_count (rsp_fill_count)
   );

   deque_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_fill_count (rsp_fill_count),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs on either channel.
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

   // Offers one request and returns at the edge where it is taken.
   // A random gap goes in front of it; valid only ever drops inside that gap,
   // so a back-to-back request never lowers and raises valid in one step.
   task automatic send_request(input logic [deq_pkg::KIND_WIDTH-1:0] kind,
                               input logic [deq_pkg::VALUE_WIDTH-1:0] value);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_push_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly random words, with the all-zero and all-one patterns mixed in.
   function automatic logic [deq_pkg::VALUE_WIDTH-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 16) return '1;
      return $urandom;
   endfunction

   // push_pct steers the fill level: high fills toward full, low drains to empty.
   function automatic logic [deq_pkg::KIND_WIDTH-1:0] pick_kind(input int push_pct);
      deq_pkg::kind_type read_kinds [4];
      int                roll;
      read_kinds = '{deq_pkg::KIND_POP_L, deq_pkg::KIND_POP_R,
                     deq_pkg::KIND_PEEK_L, deq_pkg::KIND_PEEK_R};
      roll = $urandom_range(99);
      if (roll < NOISE_PCT)
         return deq_pkg::KIND_WIDTH'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
      if (roll < NOISE_PCT + push_pct)
         return deq_pkg::KIND_PUSH_R;
      return read_kinds[2'($urandom_range(3))];
   endfunction

   // Response side: random stalls, none in the calm window, and one long
   // block that lets the deque back up into the request channel.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_due) begin
            hold_due = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Request side and verdict.
   initial begin
      int push_pct;
      int bias_pick;
      req_valid      = 1'b0;
      req_kind       = '0;
      req_push_value = '0;
      reset          = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every read kind on an empty deque: status empty, nothing moves
      send_request(deq_pkg::KIND_POP_L, '0);
      send_request(deq_pkg::KIND_POP_R, '0);
      send_request(deq_pkg::KIND_PEEK_L, '0);
      send_request(deq_pkg::KIND_PEEK_R, '0);
      // unused kinds are ignored; push_value must not matter
      for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
         send_request(deq_pkg::KIND_WIDTH'(k), '1);
      // value extremes, then fill to the brim
      send_request(deq_pkg::KIND_PUSH_R, '0);
      send_request(deq_pkg::KIND_PUSH_R, '1);
      repeat (14) send_request(deq_pkg::KIND_PUSH_R, $urandom);
      // push into a full deque is refused
      send_request(deq_pkg::KIND_PUSH_R, $urandom);
      // both ends of a full deque
      send_request(deq_pkg::KIND_PEEK_L, $urandom);
      send_request(deq_pkg::KIND_PEEK_R, $urandom);

      // Random traffic in phases that lean toward filling, draining or neither,
      // so the deque keeps crossing both empty and full and wraps its pointer.
      push_pct = 50;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % CHUNK_ITEMS == 0) begin
            bias_pick = $urandom_range(2);
            push_pct  = (bias_pick == 0) ? 75 : (bias_pick == 1) ? 22 : 48;
         end
         if (i == HOLD_AT) begin
            hold_due = 1'b1;
            push_pct = 80;
         end
         calm = (i >= CALM_FIRST && i < CALM_LAST);
         if (i == DRAIN_AT) begin
            // let everything in flight come back before going on
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         send_request(pick_kind(push_pct), pick_value());
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // catch any stray response the block might still put out
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
